>>> hdl/qsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsd_pkg
// Shared types, character codes and helpers for the query string decoder.
// ----------------------------------------------------------------------------
package qsd_pkg;

  localparam int unsigned QSD_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_KEY_END    = 3'd1,
    KIND_VALUE_BYTE = 3'd2,
    KIND_PAIR_END   = 3'd3,
    KIND_KEY_DROP   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_ESC1  = 2'd2,
    PH_ESC2  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       malformed;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic result_t mk_result(input logic [7:0] data, input kind_t kind,
                                        input logic malformed);
    result_t r;
    r.data      = data;
    r.kind      = kind;
    r.malformed = malformed;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/query_string_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_string_decoder
// Form-urlencoded query string decoder: one byte in, tagged key/value
// bytes out.
//
//   channel | direction | signals
//   in_     | input     | in_valid, in_ready, in_byte, in_last
//   out_    | output    | out_valid, out_ready, out_byte, out_kind,
//           |           | out_malformed, out_last
//
// One byte per cycle is accepted while in_ready is high; a byte is held in
// the input register until two queue slots are free, and its results are then
// written to the queue; out_valid is high while the queue holds a result.
// Bytes giving two results fill the queue faster than it drains; in_ready
// drops while the input register holds a byte and fewer than two queue slots
// are free (FifoDepth sets this).
// Synchronous active-low reset returns the decoder to the key phase and
// empties the queue.
// ----------------------------------------------------------------------------
module query_string_decoder #(
  parameter int unsigned FifoDepth = qsd_pkg::QSD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_malformed,
  output logic       out_last
);
  import qsd_pkg::*;

  push_t push;
  logic  space;

  qsd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .space    (space),
    .push     (push)
  );

  qsd_outq #(
    .Depth (FifoDepth)
  ) u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .space         (space),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_malformed (out_malformed),
    .out_last      (out_last)
  );

endmodule

>>> hdl/qsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsd_core
// Input register, decode state and the single-pass decode step. Each byte
// yields zero, one or two results handed to the output queue.
// ----------------------------------------------------------------------------
module qsd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           space,
  output qsd_pkg::push_t push
);
  import qsd_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;

  phase_t     phase_r, phase_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       seen_r, seen_nxt;
  logic       broken_r, broken_nxt;

  logic [4:0] hx;
  logic [7:0] tk_acc;
  logic       tk_seen;
  logic       tk_broken;
  result_t    esc_cur;
  result_t    esc_tk;
  result_t    r0, r1;
  logic [1:0] n;

  assign s1_fire  = s1_valid_r && space;
  assign in_ready = !s1_valid_r || space;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  // escape digit intake
  always_comb begin
    hx        = hex_digit(s1_byte_r);
    tk_acc    = acc_r;
    tk_seen   = seen_r;
    tk_broken = broken_r;
    if (!broken_r) begin
      if (hx[4]) begin
        tk_acc  = {acc_r[3:0], hx[3:0]};
        tk_seen = 1'b1;
      end else begin
        tk_broken = 1'b1;
      end
    end
    esc_cur = mk_result(seen_r ? acc_r : 8'h00, KIND_VALUE_BYTE, !seen_r);
    esc_tk  = mk_result(tk_seen ? tk_acc : 8'h00, KIND_VALUE_BYTE, !tk_seen);
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    broken_nxt = broken_r;
    r0 = mk_result(8'h00, KIND_PAIR_END, 1'b0);
    r1 = mk_result(8'h00, KIND_PAIR_END, 1'b0);
    n  = 2'd0;
    unique case (phase_r)
      PH_KEY: begin
        if (s1_byte_r == CH_EQUAL) begin
          r0 = mk_result(8'h00, KIND_KEY_END, 1'b0);
          phase_nxt = PH_VALUE;
        end else begin
          r0 = mk_result(s1_byte_r, KIND_KEY_BYTE, 1'b0);
          r1 = mk_result(8'h00, KIND_KEY_DROP, 1'b0);
        end
        n = s1_last_r ? 2'd2 : 2'd1;
      end
      PH_VALUE: begin
        if (s1_byte_r == CH_AMP) begin
          n = 2'd1;
          phase_nxt = PH_KEY;
        end else if (s1_byte_r == CH_PERCENT) begin
          acc_nxt    = 8'h00;
          seen_nxt   = 1'b0;
          broken_nxt = 1'b0;
          phase_nxt  = PH_ESC1;
          r0 = mk_result(8'h00, KIND_VALUE_BYTE, 1'b1);
          n  = s1_last_r ? 2'd2 : 2'd0;
        end else begin
          r0 = mk_result((s1_byte_r == CH_PLUS) ? CH_SPACE : s1_byte_r,
                         KIND_VALUE_BYTE, 1'b0);
          n  = s1_last_r ? 2'd2 : 2'd1;
        end
      end
      PH_ESC1, PH_ESC2: begin
        if (s1_byte_r == CH_AMP) begin
          r0 = esc_cur;
          n  = 2'd2;
          acc_nxt    = 8'h00;
          seen_nxt   = 1'b0;
          broken_nxt = 1'b0;
          phase_nxt  = PH_KEY;
        end else if (phase_r == PH_ESC1 && !s1_last_r) begin
          acc_nxt    = tk_acc;
          seen_nxt   = tk_seen;
          broken_nxt = tk_broken;
          phase_nxt  = PH_ESC2;
        end else begin
          r0 = esc_tk;
          n  = s1_last_r ? 2'd2 : 2'd1;
          acc_nxt    = 8'h00;
          seen_nxt   = 1'b0;
          broken_nxt = 1'b0;
          phase_nxt  = PH_VALUE;
        end
      end
      default: begin
        phase_nxt = PH_KEY;
      end
    endcase
    if (s1_last_r) begin
      phase_nxt  = PH_KEY;
      acc_nxt    = 8'h00;
      seen_nxt   = 1'b0;
      broken_nxt = 1'b0;
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KEY;
      acc_r    <= 8'h00;
      seen_r   <= 1'b0;
      broken_r <= 1'b0;
    end else if (s1_fire) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      broken_r <= broken_nxt;
    end
  end

  assign push.count = s1_fire ? n : 2'd0;
  assign push.res0  = r0;
  assign push.res1  = r1;

endmodule

>>> hdl/qsd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsd_outq
// Result queue: takes up to two results per cycle, presents one per cycle.
// ----------------------------------------------------------------------------
module qsd_outq #(
  parameter int unsigned Depth = qsd_pkg::QSD_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qsd_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic [2:0]     out_kind,
  output logic           out_malformed,
  output logic           out_last
);
  import qsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t             mem [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [PtrW-1:0]     wr_ptr_1;
  logic                pop;
  result_t             head;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_1 = ptr_inc(wr_ptr_r);
  assign pop      = out_valid && out_ready;
  assign space    = cnt_r <= CntW'(Depth - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.res1;
    end
  end

  assign head          = mem[rd_ptr_r];
  assign out_valid     = cnt_r != '0;
  assign out_byte      = head.data;
  assign out_kind      = head.kind;
  assign out_malformed = head.malformed;
  assign out_last      = head.last;

endmodule

>>> hdl/qsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsd_checker
// Port-level checks for the query string decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [2:0] out_kind,
  input logic       out_malformed,
  input logic       out_last
);
  import qsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_malformed) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_mal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |-> out_kind == KIND_VALUE_BYTE && out_byte == 8'h00)
    else $error("malformed flag on non-zero or non-value result");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_KEY_END || out_kind == KIND_PAIR_END
      || out_kind == KIND_KEY_DROP) |-> out_byte == 8'h00)
    else $error("marker result carries data");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_KEY_DROP |-> out_last)
    else $error("drop marker not last of its input");

endmodule

bind query_string_decoder qsd_checker u_qsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_kind      (out_kind),
  .out_malformed (out_malformed),
  .out_last      (out_last)
);

>>> tb/sv/qsd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsd_stream_checker
// Watches both channels of the query string decoder. Decodes every accepted
// input byte with its own key/value/escape tracker and checks each accepted
// output transaction, field by field, against the oldest pending result.
// ----------------------------------------------------------------------------
module qsd_stream_checker
  import qsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [2:0] out_kind,
  input  logic       out_malformed,
  input  logic       out_last,
  output int         outstanding,
  output int         fail_count
);

  localparam int MAX_REPORTS = 10;

  phase_t     qs_phase = PH_KEY;
  logic [7:0] esc_acc = 8'h00;
  logic       esc_digits = 1'b0;
  logic       esc_broken = 1'b0;
  result_t    expected_results[$];
  int         step_results = 0;
  int         errors = 0;

  function automatic result_t plain_result(input logic [7:0] data, input kind_t kind);
    result_t r;
    r = '{data: data, kind: kind, malformed: 1'b0, last: 1'b0};
    return r;
  endfunction

  function automatic void expect_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
    step_results++;
  endfunction

  function automatic void clear_escape();
    esc_acc = 8'h00;
    esc_digits = 1'b0;
    esc_broken = 1'b0;
  endfunction

  // decoded escape byte; zero and flagged when no hex digit was taken
  function automatic result_t escape_result();
    result_t r;
    r = plain_result(esc_digits ? esc_acc : 8'h00, KIND_VALUE_BYTE);
    r.malformed = !esc_digits;
    clear_escape();
    return r;
  endfunction

  function automatic void take_escape_byte(input logic [7:0] c);
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b1;
    nib = c[3:0];
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = c[3:0] + 4'd9;
    end else if (!(c inside {[8'h30:8'h39]})) begin
      is_hex = 1'b0;
    end
    if (!esc_broken) begin
      if (is_hex) begin
        esc_acc = {esc_acc[3:0], nib};
        esc_digits = 1'b1;
      end else begin
        esc_broken = 1'b1;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    step_results = 0;
    case (qs_phase)
      PH_KEY: begin
        if (c == CH_EQUAL) begin
          expect_result(plain_result(8'h00, KIND_KEY_END));
          qs_phase = PH_VALUE;
          if (fin) expect_result(plain_result(8'h00, KIND_PAIR_END));
        end else begin
          expect_result(plain_result(c, KIND_KEY_BYTE));
          if (fin) expect_result(plain_result(8'h00, KIND_KEY_DROP));
        end
      end
      PH_VALUE: begin
        if (c == CH_AMP) begin
          expect_result(plain_result(8'h00, KIND_PAIR_END));
          qs_phase = PH_KEY;
        end else if (c == CH_PERCENT) begin
          clear_escape();
          qs_phase = PH_ESC1;
          if (fin) begin
            expect_result(escape_result());
            expect_result(plain_result(8'h00, KIND_PAIR_END));
          end
        end else begin
          expect_result(plain_result(c == CH_PLUS ? CH_SPACE : c, KIND_VALUE_BYTE));
          if (fin) expect_result(plain_result(8'h00, KIND_PAIR_END));
        end
      end
      default: begin
        if (c == CH_AMP) begin
          expect_result(escape_result());
          expect_result(plain_result(8'h00, KIND_PAIR_END));
          qs_phase = PH_KEY;
        end else begin
          take_escape_byte(c);
          if (qs_phase == PH_ESC1 && !fin) begin
            qs_phase = PH_ESC2;
          end else begin
            expect_result(escape_result());
            qs_phase = PH_VALUE;
            if (fin) expect_result(plain_result(8'h00, KIND_PAIR_END));
          end
        end
      end
    endcase
    if (fin) begin
      qs_phase = PH_KEY;
      clear_escape();
    end
    if (step_results > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      qs_phase = PH_KEY;
      clear_escape();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected transaction: byte %02h kind %0d malformed %0b last %0b",
                     out_byte, out_kind, out_malformed, out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_byte !== want.data || out_kind !== want.kind ||
              out_malformed !== want.malformed || out_last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"mismatch: expected byte %02h kind %0d malformed %0b last %0b,",
                        " got byte %02h kind %0d malformed %0b last %0b"},
                       want.data, want.kind, want.malformed, want.last,
                       out_byte, out_kind, out_malformed, out_last);
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
    end
    outstanding <= expected_results.size();
    fail_count <= errors;
  end

endmodule

>>> tb/sv/tb_query_string_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_query_string_decoder
// Feeds the query string decoder directed corner cases, then random query
// strings (well-formed pairs with escapes, truncated strings, raw noise)
// under three idle/stall mixes, with a long output hold-off and a drain
// pause. Checking is done by qsd_stream_checker.
// ----------------------------------------------------------------------------
module tb_query_string_decoder;
  import qsd_pkg::*;

  localparam int    LIMIT_CYCLES = 200000;
  localparam int    HOLD_CYCLES = 300;
  localparam int    DRAIN_CYCLES = 20;
  localparam int    PHASE_ITEMS = 400;
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";

  typedef logic [7:0] query_t[$];

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_malformed;
  logic       out_last;

  int outstanding;
  int fail_count;
  int cycle_count = 0;
  int items_sent = 0;
  int send_idle_pct = 6;
  int recv_stall_pct = 61;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  query_string_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_malformed(out_malformed),
    .out_last     (out_last)
  );

  qsd_stream_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_malformed(out_malformed),
    .out_last     (out_last),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_query_string_decoder: errors");
      $finish;
    end
  end

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic query_t random_query();
    query_t q;
    int     npairs;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) q.insert(q.size(), 8'($urandom_range(255)));
      return q;
    end
    npairs = $urandom_range(1, 3);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) q.insert(q.size(), CH_AMP);
      repeat ($urandom_range(0, 4))
        q.insert(q.size(), $urandom_range(4) == 0 ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(8'h61, 8'h7a)));
      if ($urandom_range(15) == 0) break;
      q.insert(q.size(), CH_EQUAL);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(9))
          0, 1: begin
            q.insert(q.size(), CH_PERCENT);
            repeat (2)
              q.insert(q.size(), $urandom_range(9) < 7 ? 8'(HEX_CHARS[$urandom_range(21)])
                                                       : 8'($urandom_range(255)));
          end
          2: q.insert(q.size(), CH_PLUS);
          3: q.insert(q.size(), 8'($urandom_range(255)));
          default: q.insert(q.size(), 8'($urandom_range(8'h61, 8'h7a)));
        endcase
      end
    end
    if (q.size() == 0) q.insert(q.size(), 8'($urandom_range(255)));
    if (q.size() > 1 && $urandom_range(4) == 0) q = q[0:$urandom_range(0, q.size() - 2)];
    return q;
  endfunction

  task automatic random_phase(input bit with_hold);
    query_t q;
    int     target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      if (with_hold && items_sent >= target - PHASE_ITEMS / 2 &&
          hold_requests == 0)
        hold_requests <= hold_requests + 1;
      q = random_query();
      foreach (q[i]) send(q[i], i == q.size() - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 6;
    recv_stall_pct <= 61;
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(CH_AMP, 1'b0);
    send(CH_EQUAL, 1'b0);
    send(CH_PLUS, 1'b0);
    send(CH_PERCENT, 1'b0);
    send("A", 1'b0);
    send("f", 1'b0);
    send(CH_PERCENT, 1'b0);
    send("z", 1'b0);
    send("5", 1'b0);
    send(CH_PERCENT, 1'b0);
    send("7", 1'b0);
    send(CH_AMP, 1'b0);
    send(CH_EQUAL, 1'b0);
    send(CH_PERCENT, 1'b0);
    send("3", 1'b1);
    send(CH_EQUAL, 1'b1);
    send("k", 1'b1);
    send(CH_EQUAL, 1'b0);
    send(CH_PERCENT, 1'b1);
    send(CH_EQUAL, 1'b0);
    send(CH_AMP, 1'b1);
    send(CH_EQUAL, 1'b0);
    send(8'hFF, 1'b1);

    random_phase(1'b1);
    wait_drained();

    send_idle_pct = 61;
    recv_stall_pct <= 6;
    random_phase(1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct <= 0;
    random_phase(1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_query_string_decoder: clean");
    end else begin
      $display("tb_query_string_decoder: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/qsd_pkg.sv
hdl/qsd_core.sv
hdl/qsd_outq.sv
hdl/query_string_decoder.sv
hdl/qsd_checker.sv
tb/sv/qsd_stream_checker.sv
tb/sv/tb_query_string_decoder.sv
